// File: sv/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types and constants for the breakpoint hit counter unit.
// ----------------------------------------------------------------------------
package bhc_pkg;

    localparam int DEFAULT_COUNTER_SLOTS = 8;
    localparam int MAX_COUNTER_SLOTS     = 64;
    localparam int FILL_W                = 7;

    localparam logic [2:0] OP_OBSERVE   = 3'd0;
    localparam logic [2:0] OP_ADD       = 3'd1;
    localparam logic [2:0] OP_READ_CNT  = 3'd2;
    localparam logic [2:0] OP_ARM       = 3'd3;
    localparam logic [2:0] OP_READ_EVT  = 3'd4;
    localparam logic [2:0] OP_RESUME    = 3'd5;

    // command broadcast to every counter cell
    typedef struct packed {
        logic              count_en;
        logic              add_en;
        logic              read_en;
        logic [15:0]       seg;
        logic [15:0]       offset;
        logic [7:0]        read_idx;
        logic [FILL_W-1:0] fill;
    } bhc_cmd_t;

endpackage

// File: sv/bhc_cell.sv
// ----------------------------------------------------------------------------
// bhc_cell
// One address counter slot; passes the read data chain on to its neighbor.
// ----------------------------------------------------------------------------
module bhc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  bhc_pkg::bhc_cmd_t cmd,
    input  logic [31:0]       chain_in,
    output logic [31:0]       chain_out
);
    import bhc_pkg::*;

    logic [15:0] seg_reg;
    logic [15:0] offset_reg;
    logic [31:0] count_reg;
    logic        in_use;
    logic        hit;
    logic        selected;

    assign in_use   = FILL_W'(CELL_IDX) < cmd.fill;
    assign hit      = in_use && (seg_reg == cmd.seg) && (offset_reg == cmd.offset);
    assign selected = cmd.read_en && in_use && (cmd.read_idx == 8'(CELL_IDX));

    assign chain_out = chain_in | (selected ? count_reg : 32'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.add_en && (cmd.fill == FILL_W'(CELL_IDX)))
        begin
            seg_reg    <= cmd.seg;
            offset_reg <= cmd.offset;
            count_reg  <= 32'd0;
        end
        else if (cmd.count_en && hit)
        begin
            count_reg <= count_reg + 32'd1;
        end
    end

endmodule

// File: sv/breakpoint_hit_counter_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_hit_counter_unit
// Fetch address watcher with a row of hit counters and one counted breakpoint.
// ----------------------------------------------------------------------------
// usage:
//  s_* carries one command beat: s_tuser is the opcode (observe, add counter,
//  read counter, arm, read event, resume), s_tdata the operands.
//  m_* returns exactly one result beat per command.
//  each command is handled combinationally and its result sits in the output
//  register on the next cycle; a new command can be taken every cycle while
//  the receiver keeps up. the counter row compares every slot against the
//  fetch address side by side; the read data ripples through the row.
//  when the receiver stalls the result holds, and s_tready stays low until
//  the result beat is taken.
//  reset clears the fill count, breakpoint, event and skip state; slot
//  contents are only read below the fill count so they need no clearing.
// ----------------------------------------------------------------------------
module breakpoint_hit_counter_unit #(
    parameter int COUNTER_SLOTS = bhc_pkg::DEFAULT_COUNTER_SLOTS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seg[15:0], offset[31:16], ordinal[63:32], counter_index[71:64],
    // capture[72], cycle_stamp[104:73], zero fill to 111
    input  logic [111:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok[0], halt[1], counter_value[33:2], slot_index[39:34],
    // pending_flag[40], armed_flag[41], event_serial[73:42],
    // event_ordinal[105:74], event_seg[121:106], event_offset[137:122],
    // event_cycle[169:138], zero fill to 175
    output logic [175:0] m_tdata
);
    import bhc_pkg::*;

    localparam int CNT_W = $clog2(COUNTER_SLOTS + 1);

    // input fields
    logic [2:0]  opcode;
    logic [15:0] seg;
    logic [15:0] offset;
    logic [31:0] ordinal;
    logic [7:0]  counter_index;
    logic        capture;
    logic [31:0] cycle_stamp;

    assign opcode        = s_tuser;
    assign seg           = s_tdata[15:0];
    assign offset        = s_tdata[31:16];
    assign ordinal       = s_tdata[63:32];
    assign counter_index = s_tdata[71:64];
    assign capture       = s_tdata[72];
    assign cycle_stamp   = s_tdata[104:73];

    logic m_tvalid_reg;
    logic s_fire;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // control state
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             armed_reg, armed_next;
    logic             pending_reg, pending_next;
    logic             skip_once_reg, skip_once_next;
    logic [15:0]      skip_seg_reg, skip_seg_next;
    logic [15:0]      skip_offset_reg, skip_offset_next;
    logic [15:0]      target_seg_reg, target_seg_next;
    logic [15:0]      target_offset_reg, target_offset_next;
    logic [31:0]      target_ordinal_reg, target_ordinal_next;
    logic [31:0]      hit_tally_reg, hit_tally_next;
    logic [31:0]      seq_count_reg, seq_count_next;
    logic [15:0]      rec_seg_reg, rec_seg_next;
    logic [15:0]      rec_offset_reg, rec_offset_next;
    logic [31:0]      rec_ordinal_reg, rec_ordinal_next;
    logic [31:0]      rec_cycle_reg, rec_cycle_next;
    logic [31:0]      rec_seq_reg, rec_seq_next;

    logic [175:0]     m_tdata_reg, m_tdata_next;

    bhc_cmd_t         cmd;
    logic [31:0]      chain [COUNTER_SLOTS+1];

    logic             ok;
    logic             halt;
    logic [5:0]       slot_index;
    logic [31:0]      ev_seq, ev_ord, ev_cycle;
    logic [15:0]      ev_seg, ev_offset;
    logic [31:0]      tally_inc;
    logic             count_en;

    assign tally_inc = hit_tally_reg + 32'd1;

    always_comb
    begin
        fill_next           = fill_reg;
        armed_next          = armed_reg;
        pending_next        = pending_reg;
        skip_once_next      = skip_once_reg;
        skip_seg_next       = skip_seg_reg;
        skip_offset_next    = skip_offset_reg;
        target_seg_next     = target_seg_reg;
        target_offset_next  = target_offset_reg;
        target_ordinal_next = target_ordinal_reg;
        hit_tally_next      = hit_tally_reg;
        seq_count_next      = seq_count_reg;
        rec_seg_next        = rec_seg_reg;
        rec_offset_next     = rec_offset_reg;
        rec_ordinal_next    = rec_ordinal_reg;
        rec_cycle_next      = rec_cycle_reg;
        rec_seq_next        = rec_seq_reg;
        ok         = 1'b0;
        halt       = 1'b0;
        slot_index = 6'd0;
        ev_seq     = 32'd0;
        ev_ord     = 32'd0;
        ev_cycle   = 32'd0;
        ev_seg     = 16'd0;
        ev_offset  = 16'd0;
        count_en   = 1'b0;

        if (s_fire)
        begin
            case (opcode)
                OP_OBSERVE:
                begin
                    if (pending_reg)
                    begin
                        halt = 1'b1;
                    end
                    else if (skip_once_reg && skip_seg_reg == seg
                             && skip_offset_reg == offset)
                    begin
                        skip_once_next = 1'b0;
                    end
                    else
                    begin
                        skip_once_next = 1'b0;
                        count_en       = 1'b1;
                        if (armed_reg && target_seg_reg == seg
                            && target_offset_reg == offset)
                        begin
                            hit_tally_next = tally_inc;
                            if (tally_inc == target_ordinal_reg)
                            begin
                                halt         = 1'b1;
                                pending_next = 1'b1;
                                if (capture)
                                begin
                                    seq_count_next   = seq_count_reg + 32'd1;
                                    rec_seq_next     = seq_count_reg + 32'd1;
                                    rec_ordinal_next = tally_inc;
                                    rec_seg_next     = seg;
                                    rec_offset_next  = offset;
                                    rec_cycle_next   = cycle_stamp;
                                end
                            end
                        end
                    end
                end
                OP_ADD:
                begin
                    if (fill_reg < CNT_W'(COUNTER_SLOTS))
                    begin
                        ok         = 1'b1;
                        slot_index = 6'(fill_reg);
                        fill_next  = fill_reg + CNT_W'(1);
                    end
                end
                OP_ARM:
                begin
                    if (ordinal != 32'd0 && !armed_reg && !pending_reg)
                    begin
                        ok                  = 1'b1;
                        armed_next          = 1'b1;
                        target_seg_next     = seg;
                        target_offset_next  = offset;
                        target_ordinal_next = ordinal;
                        hit_tally_next      = 32'd0;
                    end
                end
                OP_READ_EVT:
                begin
                    if (pending_reg)
                    begin
                        ok        = 1'b1;
                        ev_seq    = rec_seq_reg;
                        ev_ord    = rec_ordinal_reg;
                        ev_seg    = rec_seg_reg;
                        ev_offset = rec_offset_reg;
                        ev_cycle  = rec_cycle_reg;
                    end
                end
                OP_RESUME:
                begin
                    if (pending_reg)
                    begin
                        pending_next     = 1'b0;
                        armed_next       = 1'b0;
                        hit_tally_next   = 32'd0;
                        skip_once_next   = 1'b1;
                        skip_seg_next    = rec_seg_reg;
                        skip_offset_next = rec_offset_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // broadcast to the counter row
    always_comb
    begin
        cmd.count_en = count_en;
        cmd.add_en   = s_fire && (opcode == OP_ADD) && ok;
        cmd.read_en  = s_fire && (opcode == OP_READ_CNT);
        cmd.seg      = seg;
        cmd.offset   = offset;
        cmd.read_idx = counter_index;
        cmd.fill     = FILL_W'(fill_reg);
    end

    assign chain[0] = 32'd0;

    for (genvar k = 0; k < COUNTER_SLOTS; k++)
    begin : g_cell
        bhc_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    always_comb
    begin
        m_tdata_next = {6'd0, ev_cycle, ev_offset, ev_seg, ev_ord, ev_seq,
                        armed_next, pending_next, slot_index,
                        chain[COUNTER_SLOTS], halt, ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg           <= '0;
            armed_reg          <= 1'b0;
            pending_reg        <= 1'b0;
            skip_once_reg      <= 1'b0;
            skip_seg_reg       <= 16'd0;
            skip_offset_reg    <= 16'd0;
            target_seg_reg     <= 16'd0;
            target_offset_reg  <= 16'd0;
            target_ordinal_reg <= 32'd0;
            hit_tally_reg      <= 32'd0;
            seq_count_reg      <= 32'd0;
            rec_seg_reg        <= 16'd0;
            rec_offset_reg     <= 16'd0;
            rec_ordinal_reg    <= 32'd0;
            rec_cycle_reg      <= 32'd0;
            rec_seq_reg        <= 32'd0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            fill_reg           <= fill_next;
            armed_reg          <= armed_next;
            pending_reg        <= pending_next;
            skip_once_reg      <= skip_once_next;
            skip_seg_reg       <= skip_seg_next;
            skip_offset_reg    <= skip_offset_next;
            target_seg_reg     <= target_seg_next;
            target_offset_reg  <= target_offset_next;
            target_ordinal_reg <= target_ordinal_next;
            hit_tally_reg      <= hit_tally_next;
            seq_count_reg      <= seq_count_next;
            rec_seg_reg        <= rec_seg_next;
            rec_offset_reg     <= rec_offset_next;
            rec_ordinal_reg    <= rec_ordinal_next;
            rec_cycle_reg      <= rec_cycle_next;
            rec_seq_reg        <= rec_seq_next;
            if (s_fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
